@@ src/rras_pkg.sv @@
// ----------------------------------------------------------------------------
// rras_pkg
// Shared types, codes and helpers of the round robin aging scheduler: slot
// table entry layout, item and result records, and the memory command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package rras_pkg;

   localparam int TASK_SLOTS = 8;
   localparam int SLOT_W     = $clog2(TASK_SLOTS);
   localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

   localparam logic OP_ARRIVE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam logic CSR_QUANTUM = 1'b0;
   localparam logic CSR_AGING   = 1'b1;

   localparam logic [3:0] QUANTUM_RESET = 4'd2;
   localparam logic [3:0] AGING_RESET   = 4'd1;

   typedef enum logic [1:0] {
      PH_EMPTY = 2'd0,
      PH_READY = 2'd1,
      PH_RUN   = 2'd2,
      PH_DONE  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_FULL = 2'd1,
      STAT_REJ  = 2'd2
   } status_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] burst;
      logic [15:0] executed;
      logic [7:0]  base_prio;
      logic [15:0] dyn_prio;
      logic [15:0] switches;
   } entry_type;

   typedef struct packed {
      logic        op;
      logic [15:0] burst;
      logic [7:0]  prio;
   } req_item_type;

   typedef struct packed {
      logic [3:0] quantum;
      logic [3:0] aging;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic [2:0]  assigned_slot;
      logic [2:0]  running_slot;
      logic        cpu_busy;
      logic        finished_valid;
      logic [2:0]  finished_slot;
      logic [31:0] finish_time;
      logic [15:0] switch_count;
      logic        all_done;
   } result_type;

   typedef struct packed {
      logic              we;
      logic [SLOT_W-1:0] waddr;
      entry_type         wdata;
      logic [SLOT_W-1:0] raddr;
   } ram_cmd_type;

   function automatic logic [15:0] sat_inc16(input logic [15:0] v);
      sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

endpackage

`default_nettype wire

@@ src/round_robin_aging_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// round_robin_aging_scheduler_unit
// Task table scheduler with quantum based rescheduling and priority aging.
// ----------------------------------------------------------------------------
// Each request transfer is an arrival (tuser 0) or a time tick (tuser 1) and
// yields exactly one response transfer. The eight-entry slot table lives in a
// single-port-read, single-port-write memory, so every tick walks the table
// through that one read port: one selection scan when the quantum expires or
// nothing runs, and one aging sweep when a task runs.
// The response sits in an output register, so the next request is taken
// while a response still waits. Configuration registers: index 0 quantum
// length (reset 2), index 1 aging step (reset 1); write them only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_aging_scheduler_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // burst_length[15:0], base_priority[23:16]
   input  wire logic [0:0]  req_tuser,   // opcode[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // status[1:0], assigned_slot[4:2],
                                         // running_slot[7:5], cpu_busy[8],
                                         // finished_valid[9], finished_slot[12:10],
                                         // finish_time[44:13], switch_count[60:45],
                                         // all_done[61], zero[63:62]
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [3:0]  csr_wdata
);
   import rras_pkg::*;

   cfg_type      cfg_ff;
   req_item_type req_item;
   result_type   res;
   logic         res_valid;
   logic         res_ready;
   ram_cmd_type  ram_cmd;
   entry_type    ram_rdata;
   logic         rsp_valid_ff;
   logic [63:0]  rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quantum <= QUANTUM_RESET;
         cfg_ff.aging   <= AGING_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_QUANTUM) begin
            cfg_ff.quantum <= csr_wdata;
         end else begin
            cfg_ff.aging <= csr_wdata;
         end
      end
   end

   assign req_item.op    = req_tuser[0];
   assign req_item.burst = req_tdata[15:0];
   assign req_item.prio  = req_tdata[23:16];

   rras_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_item  (req_item),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .ram_cmd   (ram_cmd),
      .ram_rdata (ram_rdata)
   );

   rras_slot_ram u_ram (
      .clock (clock),
      .cmd   (ram_cmd),
      .rdata (ram_rdata)
   );

   // load a new response only once the previous one has been transferred
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= {2'b00, res.all_done, res.switch_count, res.finish_time,
                         res.finished_slot, res.finished_valid, res.cpu_busy,
                         res.running_slot, res.assigned_slot, res.status};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

@@ src/rras_slot_ram.sv @@
// ----------------------------------------------------------------------------
// rras_slot_ram
// Slot table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rras_slot_ram (
   input  wire logic                 clock,
   input  wire rras_pkg::ram_cmd_type cmd,
   output rras_pkg::entry_type        rdata
);
   import rras_pkg::*;

   entry_type slot_mem [TASK_SLOTS];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         slot_mem[cmd.waddr] <= cmd.wdata;
      end
      rdata_ff <= slot_mem[cmd.raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ src/rras_seq.sv @@
// ----------------------------------------------------------------------------
// rras_seq
// Sequencer: loads arrivals and walks each tick through retire, selection
// scan, switch, execute and aging sweep over the slot memory.
// ----------------------------------------------------------------------------
`default_nettype none

module rras_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire rras_pkg::req_item_type req_item,
   input  wire rras_pkg::cfg_type      cfg,
   output logic                       res_valid,
   input  wire logic                  res_ready,
   output rras_pkg::result_type        res,
   output rras_pkg::ram_cmd_type       ram_cmd,
   input  wire rras_pkg::entry_type    ram_rdata
);
   import rras_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_CUR    = 8'b0000_0010,
      S_SCAN   = 8'b0000_0100,
      S_CHO_RD = 8'b0000_1000,
      S_CHO    = 8'b0001_0000,
      S_SW     = 8'b0010_0000,
      S_AGE    = 8'b0100_0000,
      S_OUT    = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  done_ff, done_in;
   logic [SLOT_W-1:0] cur_ff, cur_in;
   logic [SLOT_W-1:0] chosen_ff, chosen_in;
   logic [3:0]        qc_ff, qc_in;
   logic [31:0]       time_ff, time_in;

   entry_type         cur_ent_ff, cur_ent_in;
   entry_type         cho_ent_ff, cho_ent_in;
   logic              found_ff, found_in;
   logic [SLOT_W-1:0] best_ff, best_in;
   logic [15:0]       best_dyn_ff, best_dyn_in;
   logic [CNT_W-1:0]  iss_ff, iss_in;
   logic              pend_ff, pend_in;
   logic [SLOT_W-1:0] pend_idx_ff, pend_idx_in;
   result_type        res_ff, res_in;

   logic              sweep_rd;
   logic              sweep_end;
   logic              cur_loaded;
   logic              cho_loaded;
   entry_type         rd_ent;
   logic [16:0]       aged_sum;
   logic              do_switch;

   assign sweep_rd   = (iss_ff < fill_ff);
   assign sweep_end  = !sweep_rd && !pend_ff;
   assign cur_loaded = ({1'b0, cur_ff} < fill_ff);
   assign cho_loaded = ({1'b0, chosen_ff} < fill_ff);
   assign aged_sum   = {1'b0, ram_rdata.dyn_prio} + {13'd0, cfg.aging};

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_OUT);

   always_comb begin
      res          = res_ff;
      res.all_done = (fill_ff != '0) && (done_ff == fill_ff);
   end

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      done_in     = done_ff;
      cur_in      = cur_ff;
      chosen_in   = chosen_ff;
      qc_in       = qc_ff;
      time_in     = time_ff;
      cur_ent_in  = cur_ent_ff;
      cho_ent_in  = cho_ent_ff;
      found_in    = found_ff;
      best_in     = best_ff;
      best_dyn_in = best_dyn_ff;
      iss_in      = iss_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      res_in      = res_ff;
      rd_ent      = ram_rdata;
      do_switch   = 1'b0;

      ram_cmd       = '0;
      ram_cmd.raddr = cur_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in   = '0;
               state_in = S_OUT;
               if (req_item.op == OP_TICK) begin
                  state_in = S_CUR;
               end else if (req_item.burst == 16'd0) begin
                  res_in.status = STAT_REJ;
               end else if (fill_ff >= CNT_W'(TASK_SLOTS)) begin
                  res_in.status = STAT_FULL;
               end else begin
                  ram_cmd.we                 = 1'b1;
                  ram_cmd.waddr              = fill_ff[SLOT_W-1:0];
                  ram_cmd.wdata.phase        = PH_READY;
                  ram_cmd.wdata.burst        = req_item.burst;
                  ram_cmd.wdata.executed     = 16'd0;
                  ram_cmd.wdata.base_prio    = req_item.prio;
                  ram_cmd.wdata.dyn_prio     = {8'd0, req_item.prio};
                  ram_cmd.wdata.switches     = 16'd1;
                  res_in.assigned_slot       = 3'(fill_ff[SLOT_W-1:0]);
                  fill_in                    = fill_ff + 1'b1;
               end
            end
         end

         S_CUR: begin
            if (!cur_loaded) begin
               rd_ent.phase = PH_EMPTY;
            end
            if (rd_ent.phase == PH_RUN && rd_ent.executed == rd_ent.burst) begin
               rd_ent.phase          = PH_DONE;
               rd_ent.switches       = sat_inc16(rd_ent.switches);
               ram_cmd.we            = 1'b1;
               ram_cmd.waddr         = cur_ff;
               ram_cmd.wdata         = rd_ent;
               done_in               = done_ff + 1'b1;
               res_in.finished_valid = 1'b1;
               res_in.finished_slot  = 3'(cur_ff);
               res_in.finish_time    = time_ff;
               res_in.switch_count   = rd_ent.switches;
            end
            cur_ent_in = rd_ent;
            time_in    = time_ff + 32'd1;
            if (qc_ff >= cfg.quantum || rd_ent.phase != PH_RUN) begin
               qc_in    = 4'd0;
               found_in = 1'b0;
               iss_in   = '0;
               pend_in  = 1'b0;
               state_in = S_SCAN;
            end else begin
               state_in = S_CHO_RD;
            end
         end

         S_SCAN: begin
            pend_in = 1'b0;
            if (sweep_rd) begin
               ram_cmd.raddr = iss_ff[SLOT_W-1:0];
               pend_in       = 1'b1;
               pend_idx_in   = iss_ff[SLOT_W-1:0];
               iss_in        = iss_ff + 1'b1;
            end
            if (pend_ff && ram_rdata.phase == PH_READY &&
                (!found_ff || ram_rdata.dyn_prio > best_dyn_ff)) begin
               found_in    = 1'b1;
               best_in     = pend_idx_ff;
               best_dyn_in = ram_rdata.dyn_prio;
            end
            if (sweep_end) begin
               if (found_ff) begin
                  chosen_in = best_ff;
               end
               state_in = S_CHO_RD;
            end
         end

         S_CHO_RD: begin
            ram_cmd.raddr = chosen_ff;
            state_in      = S_CHO;
         end

         S_CHO: begin
            if (!cho_loaded) begin
               rd_ent.phase = PH_EMPTY;
            end
            cho_ent_in = rd_ent;
            do_switch  = (chosen_ff != cur_ff || cur_ent_ff.phase == PH_READY) &&
                         rd_ent.phase == PH_READY;
            iss_in     = '0;
            pend_in    = 1'b0;
            if (do_switch) begin
               // park the outgoing task; the incoming one is written next cycle
               if (cur_ent_ff.phase == PH_RUN) begin
                  ram_cmd.we             = 1'b1;
                  ram_cmd.waddr          = cur_ff;
                  ram_cmd.wdata          = cur_ent_ff;
                  ram_cmd.wdata.phase    = PH_READY;
                  ram_cmd.wdata.switches = sat_inc16(cur_ent_ff.switches);
               end
               state_in = S_SW;
            end else if (cur_ent_ff.phase == PH_RUN) begin
               ram_cmd.we             = 1'b1;
               ram_cmd.waddr          = cur_ff;
               ram_cmd.wdata          = cur_ent_ff;
               ram_cmd.wdata.executed = sat_inc16(cur_ent_ff.executed);
               qc_in                  = qc_ff + 4'd1;
               res_in.cpu_busy        = 1'b1;
               res_in.running_slot    = 3'(cur_ff);
               state_in               = S_AGE;
            end else begin
               state_in = S_OUT;
            end
         end

         S_SW: begin
            ram_cmd.we             = 1'b1;
            ram_cmd.waddr          = chosen_ff;
            ram_cmd.wdata          = cho_ent_ff;
            ram_cmd.wdata.phase    = PH_RUN;
            ram_cmd.wdata.dyn_prio = {8'd0, cho_ent_ff.base_prio};
            ram_cmd.wdata.switches = sat_inc16(cho_ent_ff.switches);
            ram_cmd.wdata.executed = sat_inc16(cho_ent_ff.executed);
            cur_in                 = chosen_ff;
            qc_in                  = qc_ff + 4'd1;
            res_in.cpu_busy        = 1'b1;
            res_in.running_slot    = 3'(chosen_ff);
            state_in               = S_AGE;
         end

         S_AGE: begin
            pend_in = 1'b0;
            if (sweep_rd) begin
               ram_cmd.raddr = iss_ff[SLOT_W-1:0];
               pend_in       = 1'b1;
               pend_idx_in   = iss_ff[SLOT_W-1:0];
               iss_in        = iss_ff + 1'b1;
            end
            if (pend_ff && ram_rdata.phase == PH_READY) begin
               ram_cmd.we             = 1'b1;
               ram_cmd.waddr          = pend_idx_ff;
               ram_cmd.wdata          = ram_rdata;
               ram_cmd.wdata.dyn_prio = aged_sum[16] ? 16'hFFFF : aged_sum[15:0];
            end
            if (sweep_end) begin
               state_in = S_OUT;
            end
         end

         S_OUT: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         fill_ff   <= '0;
         done_ff   <= '0;
         cur_ff    <= '0;
         chosen_ff <= '0;
         qc_ff     <= '0;
         time_ff   <= '0;
         found_ff  <= 1'b0;
         iss_ff    <= '0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         done_ff   <= done_in;
         cur_ff    <= cur_in;
         chosen_ff <= chosen_in;
         qc_ff     <= qc_in;
         time_ff   <= time_in;
         found_ff  <= found_in;
         iss_ff    <= iss_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ent_ff  <= cur_ent_in;
      cho_ent_ff  <= cho_ent_in;
      best_ff     <= best_in;
      best_dyn_ff <= best_dyn_in;
      pend_idx_ff <= pend_idx_in;
      res_ff      <= res_in;
   end

endmodule

`default_nettype wire
